// File: sv/gradient_noise_eval_defines.svh
// Assertion macros for the gradient noise block.
// Every macro samples on the rising edge of clk and is off while rst is high.
`ifndef GRADIENT_NOISE_EVAL_DEFINES_SVH
`define GRADIENT_NOISE_EVAL_DEFINES_SVH

// Same-cycle implication
`define GNE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gne: same-cycle check failed");

// Next-cycle implication
`define GNE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gne: next-cycle check failed");

`endif

// File: sv/gne_pkg.sv
`default_nettype none
package gne_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 256;
  localparam int TIDX_W     = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;

  // Number formats
  localparam int COORD_W  = 32;
  localparam int CFRAC    = 16;
  localparam int GRAD_W   = 16;
  localparam int GFRAC    = 15;
  localparam int OUT_FRAC = 16;
  localparam int OUT_W    = 18;

  // Derived datapath widths
  localparam int OFS_W     = CFRAC + 1;
  localparam int FADE_W    = CFRAC + 1;
  localparam int K_W       = CFRAC + 2;
  localparam int PROD_W    = OFS_W + GRAD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DOT_SHIFT = CFRAC + GFRAC - OUT_FRAC;
  localparam int DOT_W     = SUM_W - DOT_SHIFT;
  localparam int DIFF_W    = DOT_W + 1;
  localparam int BPROD_W   = DIFF_W + FADE_W + 1;

  localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1) << CFRAC;
  localparam logic signed [DOT_W-1:0] OUT_MAX = DOT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [DOT_W-1:0] OUT_MIN = -DOT_W'(1 << (OUT_W - 1));

  typedef enum logic [2:0] {
    CMD_PERM  = 3'd0,
    CMD_GRAD1 = 3'd1,
    CMD_GRAD2 = 3'd2,
    CMD_GRAD3 = 3'd3,
    CMD_EVAL  = 3'd4
  } cmd_t;

  // Lookup front end to blend back end
  typedef struct packed {
    logic                         v;
    logic [CFRAC-1:0]             rx;
    logic [CFRAC-1:0]             ry;
    logic [CFRAC-1:0]             rz;
    logic [FADE_W-1:0]            sx;
    logic [FADE_W-1:0]            sy;
    logic [FADE_W-1:0]            sz;
    logic [7:0][3*GRAD_W-1:0]     g3;
    logic [3:0][2*GRAD_W-1:0]     g2;
    logic [1:0][GRAD_W-1:0]       g1;
  } lk_t;

endpackage
`default_nettype wire

// File: sv/gradient_noise_eval.sv
// Lattice gradient noise in one, two or three dimensions, one word per clock.
// Load words (tuser 0..3) fill the permutation table and the 1-D, 2-D and
// 3-D gradient tables; every entry must be loaded before an evaluate word
// (tuser 4) reads it. An evaluate word returns one Q2.16 noise value,
// saturated; load words and unknown commands return nothing. The pipeline
// takes one word per cycle; between an accepted word and its result lie
// four stages of hashing and table reads through replicated
// two-port block memories, two stages of corner dot products, two stages
// for each of the three blend levels, and the output register. The whole
// pipeline holds while a result waits on m_axis_tready. Write dimensions
// only while the block is empty.
`default_nettype none
`include "gradient_noise_eval_defines.svh"
module gradient_noise_eval import gne_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // index, perm_value, grad_x, grad_y, grad_z, coord_x, coord_y, coord_z
  input  wire logic [159:0] s_axis_tdata,
  // cmd
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // noise_value, zero fill
  output logic [23:0]       m_axis_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_wr_data
);

  logic                    en;
  logic [1:0]              dims;
  lk_t                     lk;
  logic                    res_valid;
  logic signed [DOT_W-1:0] res;
  logic [OUT_W-1:0]        noise_value;

  // Hold the pipeline only while a result waits
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Dimension register
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 2'd3;
    end else if (cfg_wr_en) begin
      dims <= cfg_wr_data;
    end
  end

  gne_lookup u_lookup (
    .clk(clk), .rst(rst), .en(en), .in_acc(s_axis_tvalid && en),
    .cmd(s_axis_tuser),
    .index(s_axis_tdata[7:0]),
    .perm_value(s_axis_tdata[15:8]),
    .grad_x(s_axis_tdata[31:16]),
    .grad_y(s_axis_tdata[47:32]),
    .grad_z(s_axis_tdata[63:48]),
    .coord_x(s_axis_tdata[95:64]),
    .coord_y(s_axis_tdata[127:96]),
    .coord_z(s_axis_tdata[159:128]),
    .dims(dims), .lk(lk)
  );

  gne_mix u_mix (
    .clk(clk), .rst(rst), .en(en), .dims(dims), .lk(lk),
    .res_valid(res_valid), .res(res)
  );

  // Saturate to the output range
  always_comb begin
    if (res > OUT_MAX) begin
      noise_value = OUT_MAX[OUT_W-1:0];
    end else if (res < OUT_MIN) begin
      noise_value = OUT_MIN[OUT_W-1:0];
    end else begin
      noise_value = res[OUT_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {{(24-OUT_W){1'b0}}, noise_value};
    end
  end

  `GNE_ASSERT_IMP(a_stall_has_result, !s_axis_tready, m_axis_tvalid)
  `GNE_ASSERT_NEXT(a_stall_holds_front, !s_axis_tready, $stable(lk.v))
  `GNE_ASSERT_IMP(a_fade_range, lk.v, lk.sx <= FADE_ONE && lk.sy <= FADE_ONE && lk.sz <= FADE_ONE)

endmodule
`default_nettype wire

// File: sv/gne_ram.sv
`default_nettype none
module gne_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr0,
  input  wire logic [ADDR_W-1:0] raddr1,
  output logic      [DATA_W-1:0] rdata0,
  output logic      [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

// File: sv/gne_lookup.sv
`default_nettype none
module gne_lookup import gne_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_acc,
  input  wire logic [2:0]               cmd,
  input  wire logic [7:0]               index,
  input  wire logic [PERM_W-1:0]        perm_value,
  input  wire logic signed [GRAD_W-1:0] grad_x,
  input  wire logic signed [GRAD_W-1:0] grad_y,
  input  wire logic signed [GRAD_W-1:0] grad_z,
  input  wire logic [COORD_W-1:0]       coord_x,
  input  wire logic [COORD_W-1:0]       coord_y,
  input  wire logic [COORD_W-1:0]       coord_z,
  input  wire logic [1:0]               dims,
  output lk_t                           lk
);

  // Stage 1: captured word
  logic              v1;
  cmd_t              cmd1;
  logic [TIDX_W-1:0] idx1;
  logic [PERM_W-1:0] pv1;
  logic [GRAD_W-1:0] gx1, gy1, gz1;
  logic [COORD_W-1:0] cx1, cy1, cz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd_t'(cmd);
      idx1 <= index[TIDX_W-1:0];
      pv1  <= perm_value;
      gx1  <= grad_x;
      gy1  <= grad_y;
      gz1  <= grad_z;
      cx1  <= coord_x;
      cy1  <= coord_y;
      cz1  <= coord_z;
    end
  end

  logic [TIDX_W-1:0]  xlo1;
  logic [CFRAC-1:0]   rx1, ry1, rz1;
  logic [2*CFRAC-1:0] sqx1, sqy1, sqz1;
  logic [TIDX_W-1:0]  i2, j2;

  assign xlo1 = cx1[CFRAC +: TIDX_W];
  assign rx1  = cx1[CFRAC-1:0];
  assign ry1  = cy1[CFRAC-1:0];
  assign rz1  = cz1[CFRAC-1:0];
  assign sqx1 = rx1 * rx1;
  assign sqy1 = ry1 * ry1;
  assign sqz1 = rz1 * rz1;

  // First hash level: perm at both x corners
  gne_ram #(.DATA_W(TIDX_W), .DEPTH(TABLE_SIZE)) u_perm_a (
    .clk(clk), .we(en && v1 && cmd1 == CMD_PERM), .waddr(idx1),
    .wdata(pv1[TIDX_W-1:0]), .re(en), .raddr0(xlo1), .raddr1(xlo1 + 1'b1),
    .rdata0(i2), .rdata1(j2)
  );

  // Stage 2
  logic              v2;
  cmd_t              cmd2;
  logic [TIDX_W-1:0] idx2;
  logic [PERM_W-1:0] pv2;
  logic [GRAD_W-1:0] gx2, gy2, gz2;
  logic [CFRAC-1:0]  rx2, ry2, rz2;
  logic [CFRAC-1:0]  qx2, qy2, qz2;
  logic [TIDX_W-1:0] ylo2, zlo2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      idx2 <= idx1;
      pv2  <= pv1;
      gx2  <= gx1;
      gy2  <= gy1;
      gz2  <= gz1;
      rx2  <= rx1;
      ry2  <= ry1;
      rz2  <= rz1;
      qx2  <= sqx1[CFRAC +: CFRAC];
      qy2  <= sqy1[CFRAC +: CFRAC];
      qz2  <= sqz1[CFRAC +: CFRAC];
      ylo2 <= cy1[CFRAC +: TIDX_W];
      zlo2 <= cz1[CFRAC +: TIDX_W];
    end
  end

  logic [TIDX_W-1:0]       yhi2;
  logic                    pwe2;
  logic [K_W-1:0]          kx2, ky2, kz2;
  logic [CFRAC+K_W-1:0]    fx2, fy2, fz2;
  logic [TIDX_W-1:0]       b00, b10, b01, b11;
  logic [GRAD_W-1:0]       g1a3, g1b3;

  assign yhi2 = ylo2 + 1'b1;
  assign pwe2 = en && v2 && cmd2 == CMD_PERM;

  // Fade products
  assign kx2 = K_W'(3 << CFRAC) - {1'b0, rx2, 1'b0};
  assign ky2 = K_W'(3 << CFRAC) - {1'b0, ry2, 1'b0};
  assign kz2 = K_W'(3 << CFRAC) - {1'b0, rz2, 1'b0};
  assign fx2 = qx2 * kx2;
  assign fy2 = qy2 * ky2;
  assign fz2 = qz2 * kz2;

  // Second hash level: low y row and high y row
  gne_ram #(.DATA_W(TIDX_W), .DEPTH(TABLE_SIZE)) u_perm_b (
    .clk(clk), .we(pwe2), .waddr(idx2), .wdata(pv2[TIDX_W-1:0]), .re(en),
    .raddr0(i2 + ylo2), .raddr1(j2 + ylo2), .rdata0(b00), .rdata1(b10)
  );

  gne_ram #(.DATA_W(TIDX_W), .DEPTH(TABLE_SIZE)) u_perm_c (
    .clk(clk), .we(pwe2), .waddr(idx2), .wdata(pv2[TIDX_W-1:0]), .re(en),
    .raddr0(i2 + yhi2), .raddr1(j2 + yhi2), .rdata0(b01), .rdata1(b11)
  );

  gne_ram #(.DATA_W(GRAD_W), .DEPTH(TABLE_SIZE)) u_grad1 (
    .clk(clk), .we(en && v2 && cmd2 == CMD_GRAD1), .waddr(idx2), .wdata(gx2),
    .re(en), .raddr0(i2), .raddr1(j2), .rdata0(g1a3), .rdata1(g1b3)
  );

  // Stage 3
  logic              v3;
  cmd_t              cmd3;
  logic [TIDX_W-1:0] idx3;
  logic [GRAD_W-1:0] gx3, gy3, gz3;
  logic [CFRAC-1:0]  rx3, ry3, rz3;
  logic [FADE_W-1:0] sx3, sy3, sz3;
  logic [TIDX_W-1:0] zlo3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  // Unused axes get zero fade so their blend passes the low side through
  always_ff @(posedge clk) begin
    if (en) begin
      cmd3 <= cmd2;
      idx3 <= idx2;
      gx3  <= gx2;
      gy3  <= gy2;
      gz3  <= gz2;
      rx3  <= rx2;
      ry3  <= ry2;
      rz3  <= rz2;
      sx3  <= fx2[CFRAC +: FADE_W];
      sy3  <= dims[1] ? fy2[CFRAC +: FADE_W] : '0;
      sz3  <= (dims == 2'd3) ? fz2[CFRAC +: FADE_W] : '0;
      zlo3 <= zlo2;
    end
  end

  logic [TIDX_W-1:0]          zhi3;
  logic [TIDX_W-1:0]          bc [4];
  logic [7:0][3*GRAD_W-1:0]   g3_rd;
  logic [3:0][2*GRAD_W-1:0]   g2_rd;

  assign zhi3  = zlo3 + 1'b1;
  assign bc[0] = b00;
  assign bc[1] = b10;
  assign bc[2] = b01;
  assign bc[3] = b11;

  // Gradient reads: four 3-D copies and two 2-D copies, two corners each
  for (genvar k = 0; k < 4; k++) begin : g_grad3
    gne_ram #(.DATA_W(3*GRAD_W), .DEPTH(TABLE_SIZE)) u_grad3 (
      .clk(clk), .we(en && v3 && cmd3 == CMD_GRAD3), .waddr(idx3),
      .wdata({gz3, gy3, gx3}), .re(en),
      .raddr0(bc[2*(k%2)]     + ((k >= 2) ? zhi3 : zlo3)),
      .raddr1(bc[2*(k%2) + 1] + ((k >= 2) ? zhi3 : zlo3)),
      .rdata0(g3_rd[2*k]), .rdata1(g3_rd[2*k+1])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_grad2
    gne_ram #(.DATA_W(2*GRAD_W), .DEPTH(TABLE_SIZE)) u_grad2 (
      .clk(clk), .we(en && v3 && cmd3 == CMD_GRAD2), .waddr(idx3),
      .wdata({gy3, gx3}), .re(en),
      .raddr0(bc[2*k]), .raddr1(bc[2*k+1]),
      .rdata0(g2_rd[2*k]), .rdata1(g2_rd[2*k+1])
    );
  end

  // Stage 4: side data lines up with the gradient read data
  logic              v4;
  cmd_t              cmd4;
  logic [CFRAC-1:0]  rx4, ry4, rz4;
  logic [FADE_W-1:0] sx4, sy4, sz4;
  logic [GRAD_W-1:0] g1a4, g1b4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd4 <= cmd3;
      rx4  <= rx3;
      ry4  <= ry3;
      rz4  <= rz3;
      sx4  <= sx3;
      sy4  <= sy3;
      sz4  <= sz3;
      g1a4 <= g1a3;
      g1b4 <= g1b3;
    end
  end

  // Gather the stage 4 word for the back end
  assign lk = '{v: v4 && cmd4 == CMD_EVAL, rx: rx4, ry: ry4, rz: rz4,
                sx: sx4, sy: sy4, sz: sz4, g3: g3_rd, g2: g2_rd,
                g1: {g1b4, g1a4}};

endmodule
`default_nettype wire

// File: sv/gne_mix.sv
`default_nettype none
module gne_mix import gne_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic [1:0]              dims,
  input  wire lk_t                     lk,
  output logic                         res_valid,
  output logic signed [DOT_W-1:0]      res
);

  // Corner c: bit 0 picks x high, bit 1 y high, bit 2 z high
  logic signed [GRAD_W-1:0] gsel [8][3];
  logic signed [OFS_W-1:0]  osel [8][3];

  always_comb begin
    logic [CFRAC-1:0] r;
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < 3; k++) begin
        r = (k == 0) ? lk.rx : ((k == 1) ? lk.ry : lk.rz);
        osel[c][k] = $signed({((c >> k) & 1) != 0, r});
        if (dims == 2'd3) begin
          gsel[c][k] = lk.g3[c][k*GRAD_W +: GRAD_W];
        end else if (dims == 2'd2) begin
          gsel[c][k] = (k < 2) ? lk.g2[c%4][k*GRAD_W +: GRAD_W] : '0;
        end else begin
          gsel[c][k] = (k == 0) ? lk.g1[c%2] : '0;
        end
      end
    end
  end

  // M1: offset by gradient products
  logic                     v1;
  logic signed [PROD_W-1:0] p1 [8][3];
  logic [FADE_W-1:0]        sx1, sy1, sz1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        for (int k = 0; k < 3; k++) begin
          p1[c][k] <= osel[c][k] * gsel[c][k];
        end
      end
      sx1 <= lk.sx;
      sy1 <= lk.sy;
      sz1 <= lk.sz;
    end
  end

  // M2: corner sums scaled to output fraction
  logic                    v2;
  logic signed [DOT_W-1:0] d2 [8];
  logic [FADE_W-1:0]       sx2, sy2, sz2;
  logic signed [SUM_W-1:0] sum1 [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      sum1[c] = SUM_W'(p1[c][0]) + SUM_W'(p1[c][1]) + SUM_W'(p1[c][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        d2[c] <= sum1[c][DOT_SHIFT +: DOT_W];
      end
      sx2 <= sx1;
      sy2 <= sy1;
      sz2 <= sz1;
    end
  end

  // M3/M4: blend along x
  logic                      v3, v4;
  logic signed [BPROD_W-1:0] xp3 [4];
  logic signed [DOT_W-1:0]   xa3 [4];
  logic signed [DOT_W-1:0]   lx4 [4];
  logic [FADE_W-1:0]         sy3, sz3, sy4, sz4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        xp3[k] <= $signed({1'b0, sx2}) *
                  (DIFF_W'(d2[2*k+1]) - DIFF_W'(d2[2*k]));
        xa3[k] <= d2[2*k];
        lx4[k] <= xa3[k] + xp3[k][CFRAC +: DOT_W];
      end
      sy3 <= sy2;
      sz3 <= sz2;
      sy4 <= sy3;
      sz4 <= sz3;
    end
  end

  // M5/M6: blend along y
  logic                      v5, v6;
  logic signed [BPROD_W-1:0] yp5 [2];
  logic signed [DOT_W-1:0]   ya5 [2];
  logic signed [DOT_W-1:0]   ly6 [2];
  logic [FADE_W-1:0]         sz5, sz6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        yp5[k] <= $signed({1'b0, sy4}) *
                  (DIFF_W'(lx4[2*k+1]) - DIFF_W'(lx4[2*k]));
        ya5[k] <= lx4[2*k];
        ly6[k] <= ya5[k] + yp5[k][CFRAC +: DOT_W];
      end
      sz5 <= sz4;
      sz6 <= sz5;
    end
  end

  // M7/M8: blend along z
  logic                      v7;
  logic signed [BPROD_W-1:0] zp7;
  logic signed [DOT_W-1:0]   za7;

  always_ff @(posedge clk) begin
    if (en) begin
      zp7 <= $signed({1'b0, sz6}) * (DIFF_W'(ly6[1]) - DIFF_W'(ly6[0]));
      za7 <= ly6[0];
      res <= za7 + zp7[CFRAC +: DOT_W];
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1 <= lk.v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      res_valid <= v7;
    end
  end

endmodule
`default_nettype wire
